FILE: rtl/rotate_nearest_pixel_fetch_macros.svh
// Assertion macros shared by the checker of the pixel fetch block.
`ifndef ROTATE_NEAREST_PIXEL_FETCH_MACROS_SVH
`define ROTATE_NEAREST_PIXEL_FETCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RNPF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RNPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rnpf_pkg.sv
`default_nettype none

package rnpf_pkg;

   localparam int MAX_SIDE_DEF  = 1024;
   localparam int FRAC_BITS_DEF = 14;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;
   localparam int PIX_W       = 24;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int REG_IDX_W   = 3;

   localparam logic MODE_STORE = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_SRC_HEIGHT = 3'd1,
      REG_COS_TERM   = 3'd2,
      REG_SIN_TERM   = 3'd3,
      REG_OFFSET_X   = 3'd4,
      REG_OFFSET_Y   = 3'd5
   } reg_idx_type;

   localparam logic [10:0] SRC_WIDTH_RST  = 11'd1;
   localparam logic [10:0] SRC_HEIGHT_RST = 11'd1;
   localparam logic [15:0] COS_TERM_RST   = 16'd16384;
   localparam logic [15:0] SIN_TERM_RST   = 16'd0;
   localparam logic [25:0] OFFSET_X_RST   = 26'd0;
   localparam logic [25:0] OFFSET_Y_RST   = 26'd0;

endpackage

`default_nettype wire

FILE: rtl/rnpf_ram.sv
`default_nettype none

module rnpf_ram #(
   parameter int WIDTH = rnpf_pkg::PIX_W,
   parameter int DEPTH = rnpf_pkg::MAX_SIDE_DEF * rnpf_pkg::MAX_SIDE_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rotate_nearest_pixel_fetch.sv
// Seven register stages A to G; a fetch shows its result from stage G, the output register.
// Throughput: one item per cycle unless the output stalls; the pixel store read is stage six.
// A store writes the pixel store in stage six if col and row < MAX_SIDE; it yields no result.
// Reset clears the stage valid bits and loads the register reset values.
// The pixel store is not cleared by reset and holds unknown data until written.
`default_nettype none

module rotate_nearest_pixel_fetch #(
   parameter int MAX_SIDE  = rnpf_pkg::MAX_SIDE_DEF,
   parameter int FRAC_BITS = rnpf_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // col [10:0], row [21:11], red [29:22], green [37:30], blue [45:38], zero pad
   input  logic [rnpf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_red [7:0], out_green [15:8], out_blue [23:16]
   output logic [rnpf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // inside_res [0]
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rnpf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rnpf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rnpf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int XW    = ((12 + FRAC_BITS) > 26 ? (12 + FRAC_BITS) : 26) + 1;
   localparam int PW    = XW + 16;
   localparam int SW    = PW + 1;
   localparam int DIV   = 2 * FRAC_BITS;
   localparam int QW    = SW - DIV;
   localparam int LWC   = $clog2(MAX_SIDE + 1);
   localparam int LW    = LWC > 11 ? LWC : 11;
   localparam int CMPW  = (QW > LW ? QW : LW) + 1;
   localparam int AW    = $clog2(MAX_SIDE);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int ADW   = $clog2(DEPTH);
   localparam int PIX_W = rnpf_pkg::PIX_W;
   localparam logic [SW-1:0] BIAS = {{(SW - DIV){1'b0}}, {DIV{1'b1}}};

   // Configuration registers
   logic [10:0] src_width_ff;
   logic [10:0] src_height_ff;
   logic [15:0] cos_ff;
   logic [15:0] sin_ff;
   logic [25:0] offset_x_ff;
   logic [25:0] offset_y_ff;

   rnpf_pkg::reg_idx_type csr_idx;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = rnpf_pkg::reg_idx_type'(csr_paddr[rnpf_pkg::CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= rnpf_pkg::SRC_WIDTH_RST;
         src_height_ff <= rnpf_pkg::SRC_HEIGHT_RST;
         cos_ff        <= rnpf_pkg::COS_TERM_RST;
         sin_ff        <= rnpf_pkg::SIN_TERM_RST;
         offset_x_ff   <= rnpf_pkg::OFFSET_X_RST;
         offset_y_ff   <= rnpf_pkg::OFFSET_Y_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            rnpf_pkg::REG_SRC_WIDTH:  src_width_ff  <= csr_pwdata[10:0];
            rnpf_pkg::REG_SRC_HEIGHT: src_height_ff <= csr_pwdata[10:0];
            rnpf_pkg::REG_COS_TERM:   cos_ff        <= csr_pwdata[15:0];
            rnpf_pkg::REG_SIN_TERM:   sin_ff        <= csr_pwdata[15:0];
            rnpf_pkg::REG_OFFSET_X:   offset_x_ff   <= csr_pwdata[25:0];
            rnpf_pkg::REG_OFFSET_Y:   offset_y_ff   <= csr_pwdata[25:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rnpf_pkg::REG_SRC_WIDTH:  csr_prdata = 32'(src_width_ff);
         rnpf_pkg::REG_SRC_HEIGHT: csr_prdata = 32'(src_height_ff);
         rnpf_pkg::REG_COS_TERM:   csr_prdata = 32'(cos_ff);
         rnpf_pkg::REG_SIN_TERM:   csr_prdata = 32'(sin_ff);
         rnpf_pkg::REG_OFFSET_X:   csr_prdata = 32'(offset_x_ff);
         rnpf_pkg::REG_OFFSET_Y:   csr_prdata = 32'(offset_y_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // Stage advance chain: a stage loads when it is empty or its successor loads.
   logic take_a, take_b, take_c, take_d, take_e, take_f, take_g;

   logic v_a_ff, v_b_ff, v_c_ff, v_d_ff, v_e_ff, v_f_ff, rsp_tvalid_ff;

   assign take_g     = ~rsp_tvalid_ff | rsp_tready;
   assign take_f     = ~v_f_ff | take_g;
   assign take_e     = ~v_e_ff | take_f;
   assign take_d     = ~v_d_ff | take_e;
   assign take_c     = ~v_c_ff | take_d;
   assign take_b     = ~v_b_ff | take_c;
   assign take_a     = ~v_a_ff | take_b;
   assign req_tready = take_a;

   // Stage A: fixed-point position of the named pixel.
   logic [10:0]           req_col;
   logic [10:0]           req_row;
   logic [PIX_W-1:0]      req_pix;
   logic signed [XW-1:0]  x_a_in, y_a_in;
   logic signed [XW-1:0]  x_a_ff, y_a_ff;
   logic                  mode_a_ff;
   logic [10:0]           col_a_ff, row_a_ff;
   logic [PIX_W-1:0]      pix_a_ff;

   assign req_col = req_tdata[10:0];
   assign req_row = req_tdata[21:11];
   // Kept in the order of the result bus: red lowest.
   assign req_pix = req_tdata[45:22];

   assign x_a_in = $signed(XW'(req_col) << FRAC_BITS) + XW'($signed(offset_x_ff));
   assign y_a_in = $signed(XW'(req_row) << FRAC_BITS) + XW'($signed(offset_y_ff));

   always_ff @(posedge clock) begin
      if (take_a) begin
         mode_a_ff <= req_tuser;
         col_a_ff  <= req_col;
         row_a_ff  <= req_row;
         pix_a_ff  <= req_pix;
         x_a_ff    <= x_a_in;
         y_a_ff    <= y_a_in;
      end
   end

   // Stage B: the four products.
   logic signed [PW-1:0] xc_b_in, ys_b_in, yc_b_in, xs_b_in;
   logic signed [PW-1:0] xc_b_ff, ys_b_ff, yc_b_ff, xs_b_ff;
   logic                 mode_b_ff;
   logic [10:0]          col_b_ff, row_b_ff;
   logic [PIX_W-1:0]     pix_b_ff;

   assign xc_b_in = x_a_ff * $signed(cos_ff);
   assign ys_b_in = y_a_ff * $signed(sin_ff);
   assign yc_b_in = y_a_ff * $signed(cos_ff);
   assign xs_b_in = x_a_ff * $signed(sin_ff);

   always_ff @(posedge clock) begin
      if (take_b) begin
         mode_b_ff <= mode_a_ff;
         col_b_ff  <= col_a_ff;
         row_b_ff  <= row_a_ff;
         pix_b_ff  <= pix_a_ff;
         xc_b_ff   <= xc_b_in;
         ys_b_ff   <= ys_b_in;
         yc_b_ff   <= yc_b_in;
         xs_b_ff   <= xs_b_in;
      end
   end

   // Stage C: rotated coordinates at double fraction precision.
   logic signed [SW-1:0] sx_sum_c_in, sy_sum_c_in;
   logic signed [SW-1:0] sx_sum_c_ff, sy_sum_c_ff;
   logic                 mode_c_ff;
   logic [10:0]          col_c_ff, row_c_ff;
   logic [PIX_W-1:0]     pix_c_ff;

   assign sx_sum_c_in = SW'(xc_b_ff) + SW'(ys_b_ff);
   assign sy_sum_c_in = SW'(yc_b_ff) - SW'(xs_b_ff);

   always_ff @(posedge clock) begin
      if (take_c) begin
         mode_c_ff   <= mode_b_ff;
         col_c_ff    <= col_b_ff;
         row_c_ff    <= row_b_ff;
         pix_c_ff    <= pix_b_ff;
         sx_sum_c_ff <= sx_sum_c_in;
         sy_sum_c_ff <= sy_sum_c_in;
      end
   end

   // Stage D: drop the fraction, truncating toward zero. A negative value
   // gets the fraction mask added first so that the arithmetic shift rounds up.
   logic [SW-1:0]        sx_adj, sy_adj;
   logic signed [QW-1:0] qx_d_ff, qy_d_ff;
   logic                 mode_d_ff;
   logic [10:0]          col_d_ff, row_d_ff;
   logic [PIX_W-1:0]     pix_d_ff;

   assign sx_adj = sx_sum_c_ff + (sx_sum_c_ff[SW-1] ? BIAS : '0);
   assign sy_adj = sy_sum_c_ff + (sy_sum_c_ff[SW-1] ? BIAS : '0);

   always_ff @(posedge clock) begin
      if (take_d) begin
         mode_d_ff <= mode_c_ff;
         col_d_ff  <= col_c_ff;
         row_d_ff  <= row_c_ff;
         pix_d_ff  <= pix_c_ff;
         qx_d_ff   <= $signed(sx_adj[SW-1:DIV]);
         qy_d_ff   <= $signed(sy_adj[SW-1:DIV]);
      end
   end

   // Stage E: bounds test and store address for either kind of item.
   logic [LW-1:0]          lim_w, lim_h;
   logic signed [CMPW-1:0] sx_ext, sy_ext;
   logic                   inside_e_in, store_ok_e_in, fetch_d;
   logic [AW-1:0]          addr_x, addr_y;
   logic [ADW-1:0]         addr_e_in;
   logic [ADW-1:0]         addr_e_ff;
   logic                   mode_e_ff, inside_e_ff, store_ok_e_ff;
   logic [PIX_W-1:0]       pix_e_ff;

   assign lim_w = (LW'(src_width_ff) < LW'(MAX_SIDE)) ? LW'(src_width_ff) : LW'(MAX_SIDE);
   assign lim_h = (LW'(src_height_ff) < LW'(MAX_SIDE)) ? LW'(src_height_ff) : LW'(MAX_SIDE);

   assign sx_ext = CMPW'(qx_d_ff);
   assign sy_ext = CMPW'(qy_d_ff);

   assign inside_e_in = ~sx_ext[CMPW-1] && (sx_ext < $signed(CMPW'(lim_w))) &&
                        ~sy_ext[CMPW-1] && (sy_ext < $signed(CMPW'(lim_h)));

   assign store_ok_e_in = (int'(col_d_ff) < MAX_SIDE) && (int'(row_d_ff) < MAX_SIDE);
   assign fetch_d       = (mode_d_ff == rnpf_pkg::MODE_FETCH);

   assign addr_x    = fetch_d ? sx_ext[AW-1:0] : AW'(col_d_ff);
   assign addr_y    = fetch_d ? sy_ext[AW-1:0] : AW'(row_d_ff);
   assign addr_e_in = ADW'(addr_y) * ADW'(MAX_SIDE) + ADW'(addr_x);

   always_ff @(posedge clock) begin
      if (take_e) begin
         mode_e_ff     <= mode_d_ff;
         pix_e_ff      <= pix_d_ff;
         inside_e_ff   <= inside_e_in;
         store_ok_e_ff <= store_ok_e_in;
         addr_e_ff     <= addr_e_in;
      end
   end

   // Stage F: pixel store access. Stores and fetches meet the store in
   // transfer order at this one stage, so a fetch always sees earlier stores.
   logic             ram_wr_en;
   logic [PIX_W-1:0] ram_rd_data;
   logic             inside_f_ff;
   logic             fetch_e;

   assign fetch_e   = (mode_e_ff == rnpf_pkg::MODE_FETCH);
   assign ram_wr_en = take_f & v_e_ff & ~fetch_e & store_ok_e_ff;

   rnpf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_e_ff),
      .wr_data (pix_e_ff),
      .rd_en   (take_f),
      .rd_addr (addr_e_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (take_f) begin
         inside_f_ff <= inside_e_ff;
      end
   end

   // Stage G: output register.
   logic [rnpf_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                            rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (take_g) begin
         rsp_tdata_ff <= inside_f_ff ? ram_rd_data : '0;
         rsp_tuser_ff <= inside_f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff        <= 1'b0;
         v_b_ff        <= 1'b0;
         v_c_ff        <= 1'b0;
         v_d_ff        <= 1'b0;
         v_e_ff        <= 1'b0;
         v_f_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (take_a) v_a_ff <= req_tvalid;
         if (take_b) v_b_ff <= v_a_ff;
         if (take_c) v_c_ff <= v_b_ff;
         if (take_d) v_d_ff <= v_c_ff;
         if (take_e) v_e_ff <= v_d_ff;
         // A store leaves the pipeline once it has written the pixel store.
         if (take_f) v_f_ff <= v_e_ff & fetch_e;
         if (take_g) rsp_tvalid_ff <= v_f_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

FILE: rtl/rnpf_checker.sv
`default_nettype none

`include "rotate_nearest_pixel_fetch_macros.svh"

module rnpf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rnpf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // A result that is held back keeps its contents.
   `RNPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // A position outside the source always reads as black.
   `RNPF_ASSERT_SAME(a_outside_black, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "outside pixel is not black")

   // With the output register empty, nothing can hold the pipeline back.
   `RNPF_ASSERT_SAME(a_ready_when_drained, clock, 1'b0, !rsp_tvalid, req_tready, "input stalled with empty output")

   // Reset empties the pipeline, so no result follows it directly.
   `RNPF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result present after reset")

   // Input transfers are taken while the output is not blocked.
   `RNPF_ASSERT_SAME(a_flow_on_ready, clock, reset, rsp_tready && req_tvalid, req_tready, "input stalled while output flows")

endmodule

bind rotate_nearest_pixel_fetch rnpf_checker u_rnpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
